/* rtl/core/fehf_pkg.sv */
// Shared types, command codes and constants for the fire heat field block.
// No dependencies; used by fehf_ctrl and fire_effect_heat_field_top.
`timescale 1ns / 1ps

package fehf_pkg;

  localparam int DEF_GRID_WIDTH  = 80;
  localparam int DEF_GRID_HEIGHT = 66;

  localparam logic [1:0] CMD_ADVANCE = 2'd0;
  localparam logic [1:0] CMD_SEED    = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [7:0] COOL_HI_TH   = 8'd11;
  localparam logic [7:0] COOL_HI_STEP = 8'd12;
  localparam logic [7:0] COOL_LO_TH   = 8'd3;
  localparam logic [7:0] COOL_LO_STEP = 8'd4;
  localparam logic [7:0] HOT_LEVEL    = 8'd255;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] row;
    logic [6:0] col;
    logic       change;
    logic       hot;
  } item_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } rd_res_t;

  function automatic logic [7:0] cool_cell(input logic [7:0] v);
    logic [7:0] r;
    r = 8'd0;
    if (v > COOL_HI_TH) begin
      r = v - COOL_HI_STEP;
    end else if (v > COOL_LO_TH) begin
      r = v - COOL_LO_STEP;
    end
    return r;
  endfunction

endpackage

/* rtl/core/fehf_ram.sv */
// Heat cell store: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fehf_ram #(
  parameter int DEPTH = 5280,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/fehf_ctrl.sv */
// Command sequencer: clearing pass, frame sweep, seed writes and cell reads.
// Depends on fehf_pkg; drives the ports of fehf_ram.
`timescale 1ns / 1ps

module fehf_ctrl #(
  parameter int GRID_WIDTH  = fehf_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = fehf_pkg::DEF_GRID_HEIGHT,
  parameter int CELLS       = GRID_WIDTH * GRID_HEIGHT,
  parameter int AW          = $clog2(CELLS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fehf_pkg::item_t item_in,
  output logic            busy,
  output fehf_pkg::rd_res_t res,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output logic [7:0]      mem_wdata,
  output logic [AW-1:0]   mem_raddr,
  input  logic [7:0]      mem_rdata
);

  localparam int CW        = $clog2(GRID_WIDTH);
  localparam int RW        = $clog2(GRID_HEIGHT);
  localparam int SeedBase  = (GRID_HEIGHT - 2) * GRID_WIDTH;
  localparam int SeedBase2 = (GRID_HEIGHT - 1) * GRID_WIDTH;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_INIT0   = 4'd2;
  localparam logic [3:0] S_INIT1   = 4'd3;
  localparam logic [3:0] S_ADV_A   = 4'd4;
  localparam logic [3:0] S_ADV_B   = 4'd5;
  localparam logic [3:0] S_DRAIN_A = 4'd6;
  localparam logic [3:0] S_DRAIN_B = 4'd7;
  localparam logic [3:0] S_SEED0   = 4'd8;
  localparam logic [3:0] S_SEED1   = 4'd9;
  localparam logic [3:0] S_READ0   = 4'd10;
  localparam logic [3:0] S_READ1   = 4'd11;

  logic [3:0]      state;
  logic [AW-1:0]   clr_idx;
  logic [AW-1:0]   idx;       // linear index of the cell being fetched
  logic [AW-1:0]   pidx;      // cell whose results are being written back
  logic [CW-1:0]   c_cnt;
  logic [RW-1:0]   r_cnt;
  logic [7:0]      cur;
  logic [7:0]      lft;
  logic [7:0]      rreg;
  logic [7:0]      cool_reg;
  logic            pend;
  logic [7:0]      seed_level;
  logic            rd_ok;
  fehf_pkg::item_t item;

  logic [9:0]      sum;
  logic [AW-1:0]   rd_addr;
  logic            col_ok;
  logic            row_ok;

  assign sum = 10'(cur) + 10'(lft) + 10'(rreg) + 10'(mem_rdata);
  assign rd_addr = AW'(AW'(item.row) * AW'(GRID_WIDTH)) + AW'(item.col);
  assign col_ok = 32'(item_in.col) < GRID_WIDTH;
  assign row_ok = 32'(item_in.row) < GRID_HEIGHT;

  assign busy = (state != S_IDLE);
  assign res.valid = (state == S_READ1);
  assign res.zero = ~rd_ok;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = 8'd0;
    mem_raddr = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      S_INIT0: mem_raddr = AW'(GRID_WIDTH);
      S_INIT1: mem_raddr = AW'(GRID_WIDTH - 1);
      S_ADV_A, S_DRAIN_A: begin
        mem_raddr = idx + AW'(1);
        mem_we    = pend;
        mem_waddr = pidx - AW'(GRID_WIDTH);
        mem_wdata = sum[9:2];
      end
      S_ADV_B, S_DRAIN_B: begin
        // no fetch below the last row once the sweep drains
        if (state == S_ADV_B) begin
          mem_raddr = idx + AW'(GRID_WIDTH);
        end
        mem_we    = pend;
        mem_waddr = pidx;
        mem_wdata = cool_reg;
      end
      S_SEED0: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(SeedBase) + AW'(item.col);
        mem_wdata = seed_level;
      end
      S_SEED1: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(SeedBase2) + AW'(item.col);
        mem_wdata = seed_level;
      end
      S_READ0: mem_raddr = rd_addr;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      pend       <= 1'b0;
      seed_level <= 8'd0;
      rd_ok      <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            item <= item_in;
            case (item_in.cmd)
              fehf_pkg::CMD_ADVANCE: state <= S_INIT0;
              fehf_pkg::CMD_SEED: begin
                if (item_in.change) begin
                  seed_level <= item_in.hot ? fehf_pkg::HOT_LEVEL : 8'd0;
                end
                if (col_ok) begin
                  state <= S_SEED0;
                end
              end
              fehf_pkg::CMD_READ: begin
                rd_ok <= col_ok & row_ok;
                state <= S_READ0;
              end
              default: ;
            endcase
          end
        end
        S_INIT0: begin
          idx   <= AW'(GRID_WIDTH);
          c_cnt <= '0;
          r_cnt <= RW'(1);
          pend  <= 1'b0;
          state <= S_INIT1;
        end
        S_INIT1: begin
          cur   <= mem_rdata;   // column 0 of row 1
          state <= S_ADV_A;
        end
        S_ADV_A, S_DRAIN_A: begin
          if (pend) begin
            // rdata is the cell below the pending cell
            cool_reg <= fehf_pkg::cool_cell(cur);
            lft      <= fehf_pkg::cool_cell(cur);
            cur      <= rreg;
          end else begin
            lft <= mem_rdata;   // last column of row 0 for the first cell
          end
          state <= (state == S_ADV_A) ? S_ADV_B : S_DRAIN_B;
        end
        S_ADV_B: begin
          rreg <= mem_rdata;
          pidx <= idx;
          pend <= 1'b1;
          idx  <= idx + AW'(1);
          if (c_cnt == CW'(GRID_WIDTH - 1)) begin
            c_cnt <= '0;
            if (r_cnt == RW'(GRID_HEIGHT - 2)) begin
              state <= S_DRAIN_A;
            end else begin
              r_cnt <= r_cnt + RW'(1);
              state <= S_ADV_A;
            end
          end else begin
            c_cnt <= c_cnt + CW'(1);
            state <= S_ADV_A;
          end
        end
        S_DRAIN_B: begin
          pend       <= 1'b0;
          seed_level <= 8'd0;
          state      <= S_IDLE;
        end
        S_SEED0: state <= S_SEED1;
        S_SEED1: state <= S_IDLE;
        S_READ0: state <= S_READ1;
        S_READ1: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/fire_effect_heat_field_top.sv */
// Top level of the fire heat field: command port, cell store, result register.
// Depends on fehf_pkg, fehf_ram and fehf_ctrl.
`timescale 1ns / 1ps
//
// Usage:
//   A command is taken at a rising edge with start high and busy low; its
//   fields are cmd, row, col, change and hot. cmd 0 advances one frame,
//   cmd 1 seeds one column of the bottom two rows, cmd 2 reads one cell.
//   Only a read gives a result: heat, marked by valid for one cycle. The
//   receiver cannot stall, so every valid cycle is a delivered transaction.
//   Read: the command passes through READ0 and READ1 and valid is registered
//   from READ1; busy is high in both states. Out-of-range reads return heat 0.
//   Seed: busy during the two cell writes, SEED0 and SEED1; not busy if col
//   is out of range. Advance: busy through INIT0, INIT1, the sweep and its
//   drain. The sweep fetches two cells per grid cell through the single read
//   port of the store.
//   Reset: the store is cleared one cell per cycle, all GRID_WIDTH*GRID_HEIGHT
//   cells (5280 by default), with busy high; the seed level resets to 0.
//
module fire_effect_heat_field_top #(
  parameter int GRID_WIDTH  = fehf_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = fehf_pkg::DEF_GRID_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [6:0] row,
  input  logic [6:0] col,
  input  logic       change,
  input  logic       hot,
  output logic       valid,
  output logic [7:0] heat
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);

  fehf_pkg::item_t   item_in;
  fehf_pkg::rd_res_t res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [7:0]        mem_rdata;

  assign item_in.cmd    = cmd;
  assign item_in.row    = row;
  assign item_in.col    = col;
  assign item_in.change = change;
  assign item_in.hot    = hot;

  fehf_ctrl #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT),
    .CELLS      (CELLS),
    .AW         (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item_in  (item_in),
    .busy     (busy),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  fehf_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      heat <= res.zero ? 8'd0 : mem_rdata;
    end
  end

endmodule
